/* sv/tsre_pkg.sv */
// shared types and constants for the transparent sprite rle encoder
// used by the front, queue, back and top level modules
`default_nettype none

package tsre_pkg;

    // widths fixed by the output fields
    localparam int OUT_ADDR_W = 20;
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 2;

    // default parameter values
    localparam int ADDR_BITS_DEF = 20;
    localparam int DIM_BITS_DEF  = 10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_ONLY = 2'd3;

    // register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 10'd1;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 10'd1;
    localparam logic [CFG_W-1:0] STRIDE_RST = 10'd320;

    // longest opaque run that fits the length byte
    localparam logic [15:0] MAX_RUN = 16'd255;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAIL  = 2'd2;

    // result slots of one command, in output order
    localparam int NSLOTS = 8;
    localparam logic [2:0] SLOT_START   = 3'd0;
    localparam logic [2:0] SLOT_SKIP_LO = 3'd1;
    localparam logic [2:0] SLOT_SKIP_HI = 3'd2;
    localparam logic [2:0] SLOT_PIX     = 3'd3;
    localparam logic [2:0] SLOT_CLOSE   = 3'd4;
    localparam logic [2:0] SLOT_END0    = 3'd5;
    localparam logic [2:0] SLOT_END1    = 3'd6;
    localparam logic [2:0] SLOT_FINISH  = 3'd7;

    // command queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // everything one pixel causes, as a mask of slots plus their values
    typedef struct packed {
        logic [NSLOTS-1:0]     mask;
        logic [15:0]           skip_cnt;
        logic [OUT_ADDR_W-1:0] skip_a0;
        logic [OUT_ADDR_W-1:0] skip_a1;
        logic [OUT_ADDR_W-1:0] pix_a;
        logic [7:0]            pix;
        logic                  close_fail;
        logic [OUT_ADDR_W-1:0] close_a;
        logic [7:0]            close_b;
        logic [OUT_ADDR_W-1:0] end_a0;
        logic [OUT_ADDR_W-1:0] end_a1;
        logic [OUT_ADDR_W-1:0] total;
    } t_cmd;

endpackage

`default_nettype wire

/* sv/tsre_front.sv */
// front end: configuration registers, scan position and run state
// classifies each pixel into one command; depends on tsre_pkg
`default_nettype none

module tsre_front #(
    parameter int ADDR_BITS = tsre_pkg::ADDR_BITS_DEF,
    parameter int DIM_BITS  = tsre_pkg::DIM_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tsre_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_valid,
    input  wire logic [7:0]                     i_pixel,
    input  wire logic                           i_full,
    output logic                                o_ready,
    output logic                                o_push,
    output tsre_pkg::t_cmd                      o_cmd
);

    logic [tsre_pkg::CFG_W-1:0] r_width, r_height, r_stride;
    logic                       r_size_only;

    logic                 r_in_gap, n_in_gap;
    logic [15:0]          r_run, n_run;
    logic [ADDR_BITS-1:0] r_slot, n_slot;
    logic [ADDR_BITS-1:0] r_next, n_next;
    logic [DIM_BITS-1:0]  r_col, n_col;
    logic [DIM_BITS-1:0]  r_row, n_row;
    logic                 r_seen, n_seen;
    logic                 r_failed, n_failed;

    logic [DIM_BITS-1:0] w, h, stride;
    logic [15:0]         row_skip;
    logic                accept;
    tsre_pkg::t_cmd      c;

    function automatic logic [tsre_pkg::OUT_ADDR_W-1:0] lo20(input logic [ADDR_BITS-1:0] a);
        logic [ADDR_BITS+tsre_pkg::OUT_ADDR_W-1:0] t;
        t = {{tsre_pkg::OUT_ADDR_W{1'b0}}, a};
        return t[tsre_pkg::OUT_ADDR_W-1:0];
    endfunction

    function automatic logic [DIM_BITS-1:0] to_dim(input logic [tsre_pkg::CFG_W-1:0] v);
        logic [DIM_BITS+tsre_pkg::CFG_W-1:0] t;
        t = {{DIM_BITS{1'b0}}, v};
        return t[DIM_BITS-1:0];
    endfunction

    function automatic logic [15:0] to16(input logic [DIM_BITS-1:0] v);
        logic [DIM_BITS+15:0] t;
        t = {16'd0, v};
        return t[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= tsre_pkg::WIDTH_RST;
            r_height    <= tsre_pkg::HEIGHT_RST;
            r_stride    <= tsre_pkg::STRIDE_RST;
            r_size_only <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tsre_pkg::REG_WIDTH:     r_width     <= i_cfg_data;
                tsre_pkg::REG_HEIGHT:    r_height    <= i_cfg_data;
                tsre_pkg::REG_STRIDE:    r_stride    <= i_cfg_data;
                tsre_pkg::REG_SIZE_ONLY: r_size_only <= i_cfg_data[0];
            endcase
        end
    end

    // zero width or height acts as one
    assign w        = (to_dim(r_width) == '0) ? DIM_BITS'(1) : to_dim(r_width);
    assign h        = (to_dim(r_height) == '0) ? DIM_BITS'(1) : to_dim(r_height);
    assign stride   = to_dim(r_stride);
    assign row_skip = to16(stride) - to16(w);

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_in_gap = r_in_gap;
        n_run    = r_run;
        n_slot   = r_slot;
        n_next   = r_next;
        n_seen   = r_seen;
        n_failed = r_failed;
        c        = '0;

        // first pixel of a sprite
        if (r_row == '0 && r_col == '0) begin
            n_failed = 1'b0;
            n_seen   = 1'b0;
            n_run    = '0;
            if (i_pixel != 8'd0) begin
                n_slot   = '0;
                n_in_gap = 1'b0;
            end else begin
                c.mask[tsre_pkg::SLOT_START] = 1'b1;
                n_in_gap = 1'b1;
            end
            n_next = ADDR_BITS'(1);
        end

        if (!n_failed) begin
            if (i_pixel != 8'd0) begin
                if (n_in_gap) begin
                    // skip count, then room for the run length
                    c.mask[tsre_pkg::SLOT_SKIP_LO] = 1'b1;
                    c.mask[tsre_pkg::SLOT_SKIP_HI] = 1'b1;
                    c.skip_cnt = n_run;
                    c.skip_a0  = lo20(n_next);
                    c.skip_a1  = lo20(n_next + ADDR_BITS'(1));
                    n_slot     = n_next + ADDR_BITS'(2);
                    n_next     = n_next + ADDR_BITS'(3);
                    n_in_gap   = 1'b0;
                    n_run      = '0;
                end
                c.mask[tsre_pkg::SLOT_PIX] = 1'b1;
                c.pix_a = lo20(n_next);
                c.pix   = i_pixel;
                n_next  = n_next + ADDR_BITS'(1);
                n_run   = n_run + 16'd1;
            end else begin
                n_seen = 1'b1;
                if (!n_in_gap) begin
                    c.mask[tsre_pkg::SLOT_CLOSE] = 1'b1;
                    if (n_run > tsre_pkg::MAX_RUN) begin
                        c.close_fail = 1'b1;
                        n_failed     = 1'b1;
                    end else begin
                        c.close_a = lo20(n_slot);
                        c.close_b = n_run[7:0];
                        n_in_gap  = 1'b1;
                    end
                    n_run = '0;
                end
                if (!n_failed) begin
                    n_run = n_run + 16'd1;
                end
            end
        end

        n_col = r_col + DIM_BITS'(1);
        n_row = r_row;
        if (n_col == '0 || n_col >= w) begin
            n_col = '0;
            if (!n_failed) begin
                if (!n_in_gap) begin
                    // a run open at row end closes here
                    c.mask[tsre_pkg::SLOT_CLOSE] = 1'b1;
                    if (n_run > tsre_pkg::MAX_RUN) begin
                        c.close_fail = 1'b1;
                        n_failed     = 1'b1;
                    end else begin
                        c.close_a = lo20(n_slot);
                        c.close_b = n_run[7:0];
                        n_in_gap  = 1'b1;
                    end
                    n_run = row_skip;
                end else begin
                    n_run = n_run + row_skip;
                end
            end
            n_row = r_row + DIM_BITS'(1);
            if (n_row == '0 || n_row >= h) begin
                n_row = '0;
                if (!n_failed) begin
                    c.mask[tsre_pkg::SLOT_END0]   = 1'b1;
                    c.mask[tsre_pkg::SLOT_END1]   = 1'b1;
                    c.mask[tsre_pkg::SLOT_FINISH] = 1'b1;
                    c.end_a0 = lo20(n_next);
                    c.end_a1 = lo20(n_next + ADDR_BITS'(1));
                    c.total  = n_seen ? lo20(n_next + ADDR_BITS'(2)) : '0;
                end
                n_in_gap = 1'b0;
                n_run    = '0;
                n_next   = '0;
                n_slot   = '0;
            end
        end

        // size-only mode keeps just the failure and finish reports
        if (r_size_only) begin
            c.mask[tsre_pkg::SLOT_START]   = 1'b0;
            c.mask[tsre_pkg::SLOT_SKIP_LO] = 1'b0;
            c.mask[tsre_pkg::SLOT_SKIP_HI] = 1'b0;
            c.mask[tsre_pkg::SLOT_PIX]     = 1'b0;
            c.mask[tsre_pkg::SLOT_END0]    = 1'b0;
            c.mask[tsre_pkg::SLOT_END1]    = 1'b0;
            if (!c.close_fail) begin
                c.mask[tsre_pkg::SLOT_CLOSE] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_gap <= 1'b0;
            r_run    <= '0;
            r_slot   <= '0;
            r_next   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_seen   <= 1'b0;
            r_failed <= 1'b0;
        end else if (accept) begin
            r_in_gap <= n_in_gap;
            r_run    <= n_run;
            r_slot   <= n_slot;
            r_next   <= n_next;
            r_col    <= n_col;
            r_row    <= n_row;
            r_seen   <= n_seen;
            r_failed <= n_failed;
        end
    end

    // a pixel that causes no result leaves nothing in the queue
    assign o_push = accept && (c.mask != '0);
    assign o_cmd  = c;

endmodule

`default_nettype wire

/* sv/tsre_queue.sv */
// short command queue between the front and the back end
// flop based, first in first out; depends on tsre_pkg
`default_nettype none

module tsre_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire tsre_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_nempty,
    output tsre_pkg::t_cmd      o_cmd
);

    tsre_pkg::t_cmd                  r_mem [tsre_pkg::QDEPTH];
    logic [tsre_pkg::QPTR_W-1:0]     r_wp, r_rp;
    logic [tsre_pkg::QCNT_W-1:0]     r_cnt;

    assign o_full   = (r_cnt == tsre_pkg::QCNT_W'(tsre_pkg::QDEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_cmd    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + tsre_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + tsre_pkg::QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + tsre_pkg::QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - tsre_pkg::QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* sv/tsre_back.sv */
// back end: expands one command into its results, one beat per cycle while the result stream is not stalled
// holds the output register of the result stream; depends on tsre_pkg
`default_nettype none

module tsre_back (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_nempty,
    input  wire tsre_pkg::t_cmd                  i_q_cmd,
    output logic                                 o_q_pop,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [1:0]                           o_kind,
    output logic [tsre_pkg::OUT_ADDR_W-1:0]      o_addr,
    output logic [7:0]                           o_byte,
    output logic [tsre_pkg::OUT_ADDR_W-1:0]      o_total,
    output logic                                 o_last
);

    tsre_pkg::t_cmd                  r_cmd;
    logic [tsre_pkg::NSLOTS-1:0]     r_mask, n_mask, rem;
    logic [2:0]                      sel;
    logic                            take, emit, pop;
    logic [1:0]                      kind;
    logic [tsre_pkg::OUT_ADDR_W-1:0] addr, total;
    logic [7:0]                      data;

    // lowest pending slot goes first
    always_comb begin
        priority if (r_mask[tsre_pkg::SLOT_START])   sel = tsre_pkg::SLOT_START;
        else if (r_mask[tsre_pkg::SLOT_SKIP_LO])     sel = tsre_pkg::SLOT_SKIP_LO;
        else if (r_mask[tsre_pkg::SLOT_SKIP_HI])     sel = tsre_pkg::SLOT_SKIP_HI;
        else if (r_mask[tsre_pkg::SLOT_PIX])         sel = tsre_pkg::SLOT_PIX;
        else if (r_mask[tsre_pkg::SLOT_CLOSE])       sel = tsre_pkg::SLOT_CLOSE;
        else if (r_mask[tsre_pkg::SLOT_END0])        sel = tsre_pkg::SLOT_END0;
        else if (r_mask[tsre_pkg::SLOT_END1])        sel = tsre_pkg::SLOT_END1;
        else                                         sel = tsre_pkg::SLOT_FINISH;
    end

    assign rem  = r_mask & (r_mask - tsre_pkg::NSLOTS'(1));
    assign take = !o_valid || i_ready;
    assign emit = take && (r_mask != '0);
    // refill in the same cycle the last slot leaves
    assign pop  = i_q_nempty && ((r_mask == '0) || (emit && (rem == '0)));
    assign o_q_pop = pop;

    always_comb begin
        if (pop) begin
            n_mask = i_q_cmd.mask;
        end else if (emit) begin
            n_mask = rem;
        end else begin
            n_mask = r_mask;
        end
    end

    always_comb begin
        kind  = tsre_pkg::KIND_WRITE;
        addr  = '0;
        data  = '0;
        total = '0;
        unique case (sel)
            tsre_pkg::SLOT_START: begin
                addr = '0;
            end
            tsre_pkg::SLOT_SKIP_LO: begin
                addr = r_cmd.skip_a0;
                data = r_cmd.skip_cnt[7:0];
            end
            tsre_pkg::SLOT_SKIP_HI: begin
                addr = r_cmd.skip_a1;
                data = r_cmd.skip_cnt[15:8];
            end
            tsre_pkg::SLOT_PIX: begin
                addr = r_cmd.pix_a;
                data = r_cmd.pix;
            end
            tsre_pkg::SLOT_CLOSE: begin
                if (r_cmd.close_fail) begin
                    kind = tsre_pkg::KIND_FAIL;
                end else begin
                    addr = r_cmd.close_a;
                    data = r_cmd.close_b;
                end
            end
            tsre_pkg::SLOT_END0: begin
                addr = r_cmd.end_a0;
            end
            tsre_pkg::SLOT_END1: begin
                addr = r_cmd.end_a1;
            end
            tsre_pkg::SLOT_FINISH: begin
                kind  = tsre_pkg::KIND_DONE;
                total = r_cmd.total;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_q_cmd;
        end
        if (emit) begin
            o_kind  <= kind;
            o_addr  <= addr;
            o_byte  <= data;
            o_total <= total;
            o_last  <= (rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (emit) begin
                o_valid <= 1'b1;
            end else if (take) begin
                o_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/transparent_sprite_rle_encoder.sv */
// Transparent sprite RLE encoder. Takes 8-bit pixels in row-major order (0 is
// transparent) and returns addressed byte writes that build the RLE image, then
// a finish beat with the total size or a failure beat when an opaque run exceeds
// 255 pixels. The front end takes one pixel per cycle while its 4-entry command
// queue has room; the back end sends one result beat per cycle while the result
// stream is not stalled. Outside size-only mode a pixel causes one result beat
// inside an opaque run, three at a run start after a gap, up to seven where a row end and the sprite end meet.
// A result beat's tlast marks the final beat caused by one pixel. Configuration
// is to be written by the user only while the block is idle; the block does not enforce this. It takes effect at once.
// Depends on tsre_pkg, tsre_front, tsre_queue and tsre_back.
`default_nettype none

module transparent_sprite_rle_encoder #(
    parameter int ADDR_BITS = tsre_pkg::ADDR_BITS_DEF,
    parameter int DIM_BITS  = tsre_pkg::DIM_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tsre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [tsre_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  wire logic [7:0]                     i_s_axis_tdata,   // pixel
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    output logic [47:0]                         o_m_axis_tdata,   // write_addr, write_byte, total_size
    output logic [1:0]                          o_m_axis_tuser,   // kind
    output logic                                o_m_axis_tlast
);

    logic           push, pop, full, nempty;
    tsre_pkg::t_cmd f_cmd, q_cmd;
    logic [tsre_pkg::OUT_ADDR_W-1:0] addr, total;
    logic [7:0]     data;

    tsre_front #(
        .ADDR_BITS(ADDR_BITS),
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_s_axis_tvalid),
        .i_pixel   (i_s_axis_tdata),
        .i_full    (full),
        .o_ready   (o_s_axis_tready),
        .o_push    (push),
        .o_cmd     (f_cmd)
    );

    tsre_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (f_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_nempty(nempty),
        .o_cmd   (q_cmd)
    );

    tsre_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_nempty(nempty),
        .i_q_cmd   (q_cmd),
        .o_q_pop   (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_kind    (o_m_axis_tuser),
        .o_addr    (addr),
        .o_byte    (data),
        .o_total   (total),
        .o_last    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {total, data, addr};

endmodule

`default_nettype wire

/* dv/rle_image_checker.sv */
// Result checker for the transparent sprite rle encoder: watches the register port and
// both streams, keeps its own copy of the encoder state and compares every result beat.
// Depends on tsre_pkg for register indexes, result kinds and the run length limit.
`timescale 1ns / 100ps

module rle_image_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tsre_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tsre_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_pix_valid,
    input  logic                           i_pix_ready,
    input  logic [7:0]                     i_pix,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [47:0]                    i_res_data,   // write_addr, write_byte, total_size
    input  logic [1:0]                     i_res_kind,
    input  logic                           i_res_last,
    output int                             o_mismatches,
    output int                             o_outstanding
);
    import tsre_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [19:0] addr;
        logic [7:0]  value;
        logic [19:0] total;
        logic        last;
    } rle_beat_t;

    rle_beat_t   expected_beats[$];
    int          mismatches = 0;

    logic [9:0]  reg_width;
    logic [9:0]  reg_height;
    logic [9:0]  reg_stride;
    logic        reg_size_only;

    logic        gap_open;
    logic [15:0] run_len;
    logic [19:0] slot_addr;
    logic [19:0] next_addr;
    logic [9:0]  col_pos;
    logic [9:0]  row_pos;
    logic        saw_clear;
    logic        sprite_failed;

    assign o_mismatches = mismatches;

    task automatic push_beat(input logic [1:0] kind, input logic [19:0] addr,
                             input logic [7:0] value, input logic [19:0] total);
        rle_beat_t b;
        b.kind  = kind;
        b.addr  = addr;
        b.value = value;
        b.total = total;
        b.last  = 1'b0;
        expected_beats.push_back(b);
    endtask

    task automatic emit_byte(input logic [19:0] addr, input logic [7:0] value);
        if (!reg_size_only)
            push_beat(KIND_WRITE, addr, value, 20'd0);
    endtask

    // patch the length slot of the open run, or give up on the sprite
    task automatic close_run();
        if (run_len > MAX_RUN) begin
            sprite_failed = 1'b1;
            push_beat(KIND_FAIL, 20'd0, 8'd0, 20'd0);
        end else begin
            emit_byte(slot_addr, run_len[7:0]);
            gap_open = 1'b1;
        end
    endtask

    task automatic encode_pixel(input logic [7:0] px);
        logic [9:0]  w_eff;
        logic [9:0]  h_eff;
        logic [15:0] row_skip;
        int          first;
        w_eff    = (reg_width == 10'd0) ? 10'd1 : reg_width;
        h_eff    = (reg_height == 10'd0) ? 10'd1 : reg_height;
        row_skip = {6'd0, reg_stride} - {6'd0, w_eff};
        first    = expected_beats.size();

        if (row_pos == 10'd0 && col_pos == 10'd0) begin
            sprite_failed = 1'b0;
            saw_clear     = 1'b0;
            run_len       = 16'd0;
            if (px != 8'd0) begin
                slot_addr = 20'd0;
                gap_open  = 1'b0;
            end else begin
                emit_byte(20'd0, 8'd0);
                gap_open = 1'b1;
            end
            next_addr = 20'd1;
        end

        if (!sprite_failed) begin
            if (px != 8'd0) begin
                if (gap_open) begin
                    emit_byte(next_addr, run_len[7:0]);
                    emit_byte(next_addr + 20'd1, run_len[15:8]);
                    slot_addr = next_addr + 20'd2;
                    next_addr = next_addr + 20'd3;
                    gap_open  = 1'b0;
                    run_len   = 16'd0;
                end
                emit_byte(next_addr, px);
                next_addr = next_addr + 20'd1;
                run_len   = run_len + 16'd1;
            end else begin
                saw_clear = 1'b1;
                if (!gap_open) begin
                    close_run();
                    run_len = 16'd0;
                end
                if (!sprite_failed)
                    run_len = run_len + 16'd1;
            end
        end

        col_pos = col_pos + 10'd1;
        if (col_pos == 10'd0 || col_pos >= w_eff) begin
            col_pos = 10'd0;
            if (!sprite_failed) begin
                if (!gap_open) begin
                    close_run();
                    run_len = row_skip;
                end else begin
                    run_len = run_len + row_skip;
                end
            end
            row_pos = row_pos + 10'd1;
            if (row_pos == 10'd0 || row_pos >= h_eff) begin
                row_pos = 10'd0;
                if (!sprite_failed) begin
                    emit_byte(next_addr, 8'd0);
                    emit_byte(next_addr + 20'd1, 8'd0);
                    push_beat(KIND_DONE, 20'd0, 8'd0,
                              saw_clear ? next_addr + 20'd2 : 20'd0);
                end
                gap_open  = 1'b0;
                run_len   = 16'd0;
                next_addr = 20'd0;
                slot_addr = 20'd0;
            end
        end

        if (expected_beats.size() > first)
            expected_beats[expected_beats.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [19:0] want_v,
                               input logic [19:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        rle_beat_t want;
        if (!i_rst_n) begin
            expected_beats.delete();
            reg_width     = WIDTH_RST;
            reg_height    = HEIGHT_RST;
            reg_stride    = STRIDE_RST;
            reg_size_only = 1'b0;
            gap_open      = 1'b0;
            run_len       = 16'd0;
            slot_addr     = 20'd0;
            next_addr     = 20'd0;
            col_pos       = 10'd0;
            row_pos       = 10'd0;
            saw_clear     = 1'b0;
            sprite_failed = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_WIDTH:     reg_width     = i_cfg_data;
                    REG_HEIGHT:    reg_height    = i_cfg_data;
                    REG_STRIDE:    reg_stride    = i_cfg_data;
                    REG_SIZE_ONLY: reg_size_only = i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_res_valid && i_res_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat, expected none, actual kind %0d addr %0h byte %0h size %0h last %b",
                             $time, i_res_kind, i_res_data[19:0], i_res_data[27:20],
                             i_res_data[47:28], i_res_last);
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", 20'(want.kind), 20'(i_res_kind));
                    check_field("write_addr", want.addr, i_res_data[19:0]);
                    check_field("write_byte", 20'(want.value), 20'(i_res_data[27:20]));
                    check_field("total_size", want.total, i_res_data[47:28]);
                    check_field("last", 20'(want.last), 20'(i_res_last));
                end
            end

            if (i_pix_valid && i_pix_ready)
                encode_pixel(i_pix);
        end
        o_outstanding <= expected_beats.size();
    end

endmodule

/* dv/tb_transparent_sprite_rle_encoder.sv */
// Testbench top for the transparent sprite rle encoder: drives pixels and register
// writes, throttles the result stream and reports the verdict from rle_image_checker.
// Depends on tsre_pkg, the encoder RTL and dv/rle_image_checker.sv.
`timescale 1ns / 100ps

module tb_transparent_sprite_rle_encoder;
    import tsre_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 220;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = REG_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = 8'd0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    bit src_idle   = 1'b1;
    bit sink_idle  = 1'b1;
    bit hold_req   = 1'b0;
    bit opaque_mode = 1'b0;

    logic [7:0] script[$];

    always #1 clk = ~clk;

    transparent_sprite_rle_encoder i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    rle_image_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_pix_valid   (s_tvalid),
        .i_pix_ready   (s_tready),
        .i_pix         (s_tdata),
        .i_res_valid   (m_tvalid),
        .i_res_ready   (m_tready),
        .i_res_data    (m_tdata),
        .i_res_kind    (m_tuser),
        .i_res_last    (m_tlast),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: a long hold-off on request, otherwise random stall bursts
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 6) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // all four registers, back to back, then the enable drops
    task automatic write_regs(input int w, input int h, input int stride, input bit so);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_WIDTH;
        cfg_data <= CFG_W'(w);
        @(posedge clk);
        cfg_idx  <= REG_HEIGHT;
        cfg_data <= CFG_W'(h);
        @(posedge clk);
        cfg_idx  <= REG_STRIDE;
        cfg_data <= CFG_W'(stride);
        @(posedge clk);
        cfg_idx  <= REG_SIZE_ONLY;
        cfg_data <= CFG_W'(so);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic send_pixel(input logic [7:0] px);
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge clk); while (!s_tready);
        if (src_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // wait for every expected beat, then let the pipeline settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // runs of transparent and opaque pixels, or plain noise
    function automatic logic [7:0] make_pixel(input bit noisy);
        if (noisy)
            return 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) == 0)
            opaque_mode = !opaque_mode;
        if (!opaque_mode)
            return 8'd0;
        case ($urandom_range(0, 7))
            0:       return 8'hFF;
            1:       return 8'h01;
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    initial begin
        int sent;
        int w;
        int h;
        int stride;
        int npix;
        int long_run;
        bit so;
        bit noisy;
        bit at_row_end;
        bit allow_idle;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset geometry: one transparent and one opaque single-pixel sprite
        script = '{8'd0, 8'd255};
        foreach (script[k]) send_pixel(script[k]);
        drain_results();

        // runs that close inside a row and at row ends
        write_regs(4, 3, 10, 1'b0);
        script = '{8'd0, 8'd0, 8'd7, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0,
                   8'd128, 8'd9, 8'd0, 8'd3};
        foreach (script[k]) send_pixel(script[k]);
        drain_results();

        // stride below width: the skip count wraps
        write_regs(3, 2, 1, 1'b0);
        script = '{8'd4, 8'd0, 8'd0, 8'd0, 8'd6, 8'd0};
        foreach (script[k]) send_pixel(script[k]);
        drain_results();

        // zero width and height act as one, size-only mode
        write_regs(0, 0, 1023, 1'b1);
        script = '{8'd0, 8'd77};
        foreach (script[k]) send_pixel(script[k]);
        drain_results();

        // largest geometry, then shrunk while the sprite is open
        write_regs(1023, 1023, 1023, 1'b0);
        script = '{8'd0, 8'd200, 8'd0};
        foreach (script[k]) send_pixel(script[k]);
        drain_results();
        write_regs(2, 2, 5, 1'b0);
        script = '{8'd170, 8'd85, 8'd0};
        foreach (script[k]) send_pixel(script[k]);
        drain_results();

        // opaque run around the length limit while results are held back
        long_run   = $urandom_range(255, 258);
        at_row_end = 1'($urandom_range(0, 1));
        write_regs(at_row_end ? long_run : long_run + 2, 1, $urandom_range(1, 1023), 1'b0);
        hold_req = 1'b1;
        repeat (long_run) send_pixel(8'($urandom_range(1, 255)));
        if (!at_row_end) begin
            send_pixel(8'd0);
            send_pixel(8'($urandom_range(0, 255)));
        end
        drain_results();

        sent       = 0;
        allow_idle = 1'b1;
        while (sent < RANDOM_ITEMS) begin
            if (sent > RANDOM_ITEMS * 3 / 4)
                allow_idle = 1'b0;
            src_idle  = allow_idle && ($urandom_range(0, 2) != 0);
            sink_idle = allow_idle && ($urandom_range(0, 2) != 0);

            if ($urandom_range(0, 7) == 0)
                w = 0;
            else if ($urandom_range(0, 5) == 0)
                w = $urandom_range(7, 40);
            else
                w = $urandom_range(1, 6);
            h = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
            case ($urandom_range(0, 3))
                0:       stride = 1;
                1:       stride = 1023;
                2:       stride = ((w == 0) ? 1 : w) + $urandom_range(0, 20);
                default: stride = $urandom_range(1, 1023);
            endcase
            so    = ($urandom_range(0, 4) == 0);
            noisy = ($urandom_range(0, 5) == 0);
            write_regs(w, h, stride, so);

            npix = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h) * $urandom_range(1, 3);
            // now and then leave a sprite open so the next geometry lands mid-sprite
            if (npix > 1 && $urandom_range(0, 7) == 0)
                npix -= $urandom_range(1, npix - 1);
            // keep the random phase within its pixel budget
            if (npix > RANDOM_ITEMS - sent)
                npix = RANDOM_ITEMS - sent;
            repeat (npix) begin
                send_pixel(make_pixel(noisy));
                sent++;
            end
            drain_results();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
